// ===== sv/spq_pkg.sv =====
package spq_pkg;

    // Queue depth and derived count width
    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Widths of the request and result fields
    localparam int DATA_W   = 32;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
    localparam logic [OP_W-1:0] OP_POP   = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef logic signed [DATA_W-1:0] spq_data_t;
    typedef logic [CNT_W-1:0]         spq_count_t;

    // Per-cycle command broadcast to every cell
    typedef struct packed {
        logic push;
        logic pop;
    } spq_ctrl_t;

endpackage

// ===== sv/spq_cell.sv =====
module spq_cell (
    input  logic              clk,
    input  spq_pkg::spq_ctrl_t ctrl,
    input  logic              occupied,
    input  spq_pkg::spq_data_t push_value,
    input  spq_pkg::spq_data_t left_value,
    input  logic              left_ins,
    input  spq_pkg::spq_data_t right_value,
    output spq_pkg::spq_data_t cell_value,
    output logic              ins
);
    import spq_pkg::*;

    spq_data_t value_reg;
    spq_data_t value_next;

    // Flag a cell that lies at or after the insertion point
    assign ins = !(occupied && (value_reg >= push_value));

    // Shift right on push past the insertion point, shift left on pop
    always_comb
    begin
        value_next = value_reg;
        if (ctrl.push && ins)
        begin
            if (left_ins)
                value_next = left_value;
            else
                value_next = push_value;
        end
        else if (ctrl.pop)
        begin
            value_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign cell_value = value_reg;

endmodule

// ===== sv/sorted_array_priority_queue.sv =====
// Results: a request accepted at a clock edge has its result valid from the next cycle.
// Throughput: one request per cycle when not stalled; a row of compare-and-shift cells
// inserts or removes in a single step; head and tail come from the cell registers,
// flags from the count register. The input stalls only while a finished result is
// held by a stalled output. Reset: count, status and output valid clear
// asynchronously; cell contents are left as is and are never read until written.
module sorted_array_priority_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [spq_pkg::OP_W-1:0]      operation,
    input  logic signed [spq_pkg::DATA_W-1:0] value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [spq_pkg::DATA_W-1:0] head_value,
    output logic signed [spq_pkg::DATA_W-1:0] tail_value,
    output logic [spq_pkg::CNT_W-1:0]     entry_count,
    output logic                          is_empty,
    output logic                          is_full,
    output logic [spq_pkg::STATUS_W-1:0]  status
);
    import spq_pkg::*;

    spq_count_t            count_reg;
    spq_count_t            count_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [STATUS_W-1:0]   status_reg;
    logic [STATUS_W-1:0]   status_next;

    logic                  accept;
    logic                  full;
    logic                  empty;
    spq_ctrl_t             ctrl;
    logic [CAPACITY-1:0]   occ;
    logic [CAPACITY-1:0]   ins;
    spq_data_t             cell_val [CAPACITY];
    spq_data_t             tail_mux;

    // Take a request unless a held result is stalled
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    assign full  = (count_reg == CNT_W'(CAPACITY));
    assign empty = (count_reg == '0);

    // Broadcast the command to the cells
    assign ctrl.push = accept && (operation == OP_PUSH) && !full;
    assign ctrl.pop  = accept && (operation == OP_POP) && !empty;

    // Mark occupied cells from the count
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            occ[i] = (CNT_W'(i) < count_reg);
        end
    end

    // Build the row of cells
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        spq_data_t left_v;
        spq_data_t right_v;
        logic      left_i;

        if (g == 0)
        begin : g_first
            assign left_v = value;
            assign left_i = 1'b0;
        end
        else
        begin : g_mid
            assign left_v = cell_val[g-1];
            assign left_i = ins[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign right_v = cell_val[g];
        end
        else
        begin : g_body
            assign right_v = cell_val[g+1];
        end

        spq_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .occupied    (occ[g]),
            .push_value  (value),
            .left_value  (left_v),
            .left_ins    (left_i),
            .right_value (right_v),
            .cell_value  (cell_val[g]),
            .ins         (ins[g])
        );
    end

    // Advance count, status and output valid
    always_comb
    begin
        count_next     = count_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (accept)
        begin
            out_valid_next = 1'b1;
            status_next    = ST_DONE;
            case (operation)
                OP_PUSH:
                begin
                    if (full)
                        status_next = ST_FULL;
                    else
                        count_next = count_reg + 1'b1;
                end
                OP_POP:
                begin
                    if (empty)
                        status_next = ST_EMPTY;
                    else
                        count_next = count_reg - 1'b1;
                end
                default:
                begin
                    status_next = ST_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= ST_DONE;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
        end
    end

    // Pick the last occupied cell as the tail
    always_comb
    begin
        tail_mux = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (occ[i] && ((i == CAPACITY - 1) || !occ[(i + 1) % CAPACITY]))
                tail_mux = tail_mux | cell_val[i];
        end
    end

    // Drive the result from the held state
    assign out_valid   = out_valid_reg;
    assign head_value  = empty ? '0 : cell_val[0];
    assign tail_value  = empty ? '0 : tail_mux;
    assign entry_count = count_reg;
    assign is_empty    = empty;
    assign is_full     = full;
    assign status      = status_reg;

endmodule
